// File: rtl/core/sddu_pkg.sv
`default_nettype none
package sddu_pkg;

	localparam int MAX_IN_BITS  = 6;
	localparam int MAX_OUT_BITS = 6;

	localparam int IN_BITS_W    = 3;
	localparam int IN_BITS_RST  = 4;
	localparam int INDEX_W      = 6;
	localparam int VALUE_W      = 6;
	localparam int STATUS_W     = 2;
	localparam int DIFF_W       = 6;
	localparam int COUNT_W      = 7;
	localparam int APB_ADDR_W   = 2;
	localparam int APB_DATA_W   = 32;

	localparam logic [APB_ADDR_W-1:0] ADDR_IN_BITS = '0;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_POW2  = 2'd1,
		STAT_NOT_BUILT = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CHECK,
		ST_VERIFY,
		ST_PAIR_I,
		ST_PAIR_S,
		ST_PAIR_J,
		ST_PAIR_D,
		ST_DONE,
		ST_Q_SCAN,
		ST_Q_WAIT,
		ST_Q_EMIT
	} state_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage
`default_nettype wire

// File: rtl/core/sddu_req_if.sv
`default_nettype none
interface sddu_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [sddu_pkg::INDEX_W-1:0]    index;
	logic [sddu_pkg::VALUE_W-1:0]    entry_value;
	logic                            last_entry;

	modport source (output valid, req_type, index, entry_value, last_entry, input ready);
	modport sink (input valid, req_type, index, entry_value, last_entry, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sddu_rsp_if.sv
`default_nettype none
interface sddu_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [sddu_pkg::STATUS_W-1:0]   status;
	logic [sddu_pkg::DIFF_W-1:0]     out_diff;
	logic [sddu_pkg::COUNT_W-1:0]    pair_count;
	logic                            last;

	modport source (output valid, status, out_diff, pair_count, last, input ready);
	modport sink (input valid, status, out_diff, pair_count, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sbox_difference_distribution_unit.sv
// Loads: result word registered at accept.
// Final load (build): clear 2^(b+MAX_OUT_BITS) count entries, check, then walk n*n pairs, n = 2^b;
//   the single read port of each RAM sets the pair walk to one pair per cycle within a row.
// Query: k+1 row scans for k result words, one row scan per word.
// One item at a time; reset: in_bits 4, table invalid, no output pending.
// Reset is asynchronous active low; RAM contents are not reset.
`default_nettype none
module sbox_difference_distribution_unit #(
	parameter int MAX_IN_BITS  = sddu_pkg::MAX_IN_BITS,
	parameter int MAX_OUT_BITS = sddu_pkg::MAX_OUT_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [sddu_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [sddu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [sddu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	sddu_req_if.sink                               req_ch,
	sddu_rsp_if.source                             rsp_ch
);
	localparam int IB  = MAX_IN_BITS;
	localparam int OB  = MAX_OUT_BITS;
	localparam int NW  = IB + 1;
	localparam int BW  = $clog2(IB + 1);
	localparam int CTW = IB + OB + 1;
	localparam int CW  = IB + 1;
	localparam int OBW = $clog2(OB + 1);

	sddu_pkg::state_t state_q, state_d;

	logic [sddu_pkg::IN_BITS_W-1:0] in_bits_q;
	logic                           table_valid_q;
	logic [OBW-1:0]                 obits_q;

	logic [BW-1:0] b_w;
	logic [NW-1:0] n_w;
	logic [IB-1:0] nm1_w;
	logic [OB-1:0] oszm1_w;

	always_comb begin
		if (in_bits_q == '0) begin
			b_w = BW'(1);
		end else if (32'(in_bits_q) > IB) begin
			b_w = BW'(IB);
		end else begin
			b_w = BW'(in_bits_q);
		end
		n_w     = NW'(1) << b_w;
		nm1_w   = IB'(n_w - NW'(1));
		oszm1_w = OB'((OB+1)'(1) << obits_q) - OB'(1);
	end

	assign pready = 1'b1;
	assign prdata = (paddr == sddu_pkg::ADDR_IN_BITS) ? sddu_pkg::APB_DATA_W'(in_bits_q) : '0;
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite;

	// memories
	logic              sb_we;
	logic [IB-1:0]     sb_waddr, sb_raddr;
	logic [OB-1:0]     sb_wdata, sb_rdata;
	logic              ct_we;
	logic [IB+OB-1:0]  ct_waddr, ct_raddr;
	logic [CW-1:0]     ct_wdata, ct_rdata;

	sddu_ram #(.WIDTH(OB), .DEPTH(1 << IB)) u_sbox_ram (
		.clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
		.raddr(sb_raddr), .rdata(sb_rdata)
	);

	sddu_ram #(.WIDTH(CW), .DEPTH(1 << (IB + OB))) u_count_ram (
		.clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
		.raddr(ct_raddr), .rdata(ct_rdata)
	);

	// sequencer registers
	logic [CTW-1:0] c_q;
	logic [IB-1:0]  i_q, j_q;
	logic [OB-1:0]  si_q;
	logic [OB-1:0]  top_q;
	logic           mv_s1_q;
	logic           pv_s1_q, pv_s2_q;
	logic [IB-1:0]  pj_s1_q;
	logic [IB+OB-1:0] pa_s2_q;
	logic [IB-1:0]  r_q;
	logic [OB-1:0]  od_q;
	logic           qv_s1_q;
	logic [OB-1:0]  qod_s1_q;
	logic           found_q;
	logic [CW-1:0]  best_cnt_q;
	logic [OB-1:0]  best_od_q;
	logic           pend_v_q;
	logic [CW-1:0]  pend_cnt_q;
	logic [OB-1:0]  pend_od_q;

	logic                         out_valid_q;
	logic [sddu_pkg::STATUS_W-1:0] out_status_q;
	logic [OB-1:0]                out_od_q;
	logic [CW-1:0]                out_cnt_q;
	logic                         out_last_q;

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.status      = out_status_q;
	assign rsp_ch.out_diff    = sddu_pkg::DIFF_W'(out_od_q);
	assign rsp_ch.pair_count  = sddu_pkg::COUNT_W'(out_cnt_q);
	assign rsp_ch.last        = out_last_q;

	logic out_free;
	assign out_free = !out_valid_q || rsp_ch.ready;

	logic req_acc;
	assign req_ch.ready = (state_q == sddu_pkg::ST_IDLE) && out_free;
	assign req_acc      = req_ch.valid && req_ch.ready;

	logic idx_range;
	assign idx_range = (NW + sddu_pkg::INDEX_W)'(req_ch.index) < (NW + sddu_pkg::INDEX_W)'(n_w);

	logic [IB+OB:0] c_last;
	assign c_last = CTW'((CTW'(1) << (32'(b_w) + OB)) - CTW'(1));

	logic pow2_ok;
	assign pow2_ok = (((OB+1)'(top_q) + (OB+1)'(1)) & (OB+1)'(top_q)) == '0;

	// query candidate at stage 1
	logic cand, better;
	always_comb begin
		cand = qv_s1_q && (ct_rdata != '0) &&
			(!pend_v_q || (ct_rdata < pend_cnt_q) ||
			 ((ct_rdata == pend_cnt_q) && (qod_s1_q > pend_od_q)));
		better = cand && (!found_q || (ct_rdata > best_cnt_q));
	end

	// push into output register
	logic                          push;
	logic [sddu_pkg::STATUS_W-1:0] push_status;
	logic [OB-1:0]                 push_od;
	logic [CW-1:0]                 push_cnt;
	logic                          push_last;

	always_comb begin
		state_d     = state_q;
		push        = 1'b0;
		push_status = sddu_pkg::STAT_OK;
		push_od     = '0;
		push_cnt    = '0;
		push_last   = 1'b1;
		case (state_q)
			sddu_pkg::ST_IDLE: begin
				if (req_acc) begin
					if (req_ch.req_type == sddu_pkg::REQ_LOAD) begin
						if (!idx_range) begin
							push        = 1'b1;
							push_status = sddu_pkg::STAT_RANGE;
						end else if (req_ch.last_entry) begin
							state_d = sddu_pkg::ST_CLEAR;
						end else begin
							push = 1'b1;
						end
					end else if (!table_valid_q) begin
						push        = 1'b1;
						push_status = sddu_pkg::STAT_NOT_BUILT;
					end else if (!idx_range) begin
						push        = 1'b1;
						push_status = sddu_pkg::STAT_RANGE;
					end else begin
						state_d = sddu_pkg::ST_Q_SCAN;
					end
				end
			end
			sddu_pkg::ST_CLEAR: begin
				if ((IB+OB+1)'(c_q) == c_last) state_d = sddu_pkg::ST_CHECK;
			end
			sddu_pkg::ST_CHECK: state_d = sddu_pkg::ST_VERIFY;
			sddu_pkg::ST_VERIFY: begin
				if (pow2_ok) begin
					state_d = sddu_pkg::ST_PAIR_I;
				end else if (out_free) begin
					push        = 1'b1;
					push_status = sddu_pkg::STAT_NOT_POW2;
					state_d     = sddu_pkg::ST_IDLE;
				end
			end
			sddu_pkg::ST_PAIR_I: state_d = sddu_pkg::ST_PAIR_S;
			sddu_pkg::ST_PAIR_S: state_d = sddu_pkg::ST_PAIR_J;
			sddu_pkg::ST_PAIR_J: begin
				if (j_q == nm1_w) state_d = sddu_pkg::ST_PAIR_D;
			end
			sddu_pkg::ST_PAIR_D: begin
				if (!pv_s1_q && !pv_s2_q) begin
					state_d = (i_q == nm1_w) ? sddu_pkg::ST_DONE : sddu_pkg::ST_PAIR_I;
				end
			end
			sddu_pkg::ST_DONE: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = sddu_pkg::ST_IDLE;
				end
			end
			sddu_pkg::ST_Q_SCAN: begin
				if (od_q == oszm1_w) state_d = sddu_pkg::ST_Q_WAIT;
			end
			sddu_pkg::ST_Q_WAIT: state_d = sddu_pkg::ST_Q_EMIT;
			sddu_pkg::ST_Q_EMIT: begin
				if (found_q) begin
					if (!pend_v_q) begin
						state_d = sddu_pkg::ST_Q_SCAN;
					end else if (out_free) begin
						push      = 1'b1;
						push_od   = pend_od_q;
						push_cnt  = pend_cnt_q;
						push_last = 1'b0;
						state_d   = sddu_pkg::ST_Q_SCAN;
					end
				end else if (out_free) begin
					push     = 1'b1;
					push_od  = pend_v_q ? pend_od_q : '0;
					push_cnt = pend_v_q ? pend_cnt_q : '0;
					state_d  = sddu_pkg::ST_IDLE;
				end
			end
			default: state_d = sddu_pkg::ST_IDLE;
		endcase
	end

	// RAM ports
	always_comb begin
		sb_we    = req_acc && (req_ch.req_type == sddu_pkg::REQ_LOAD) && idx_range;
		sb_waddr = IB'(req_ch.index);
		sb_wdata = OB'(req_ch.entry_value);
		case (state_q)
			sddu_pkg::ST_CLEAR:  sb_raddr = c_q[IB-1:0];
			sddu_pkg::ST_PAIR_I: sb_raddr = i_q;
			default:             sb_raddr = j_q;
		endcase
		ct_raddr = pv_s1_q ? {i_q ^ pj_s1_q, si_q ^ sb_rdata} : {r_q, od_q};
		if (state_q == sddu_pkg::ST_CLEAR) begin
			ct_we    = 1'b1;
			ct_waddr = c_q[IB+OB-1:0];
			ct_wdata = '0;
		end else begin
			ct_we    = pv_s2_q;
			ct_waddr = pa_s2_q;
			ct_wdata = ct_rdata + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sddu_pkg::ST_IDLE;
			in_bits_q     <= sddu_pkg::IN_BITS_W'(sddu_pkg::IN_BITS_RST);
			table_valid_q <= 1'b0;
			obits_q       <= '0;
			out_valid_q   <= 1'b0;
			mv_s1_q       <= 1'b0;
			pv_s1_q       <= 1'b0;
			pv_s2_q       <= 1'b0;
			qv_s1_q       <= 1'b0;
			found_q       <= 1'b0;
			pend_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				in_bits_q     <= pwdata[sddu_pkg::IN_BITS_W-1:0];
				table_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sddu_pkg::ST_VERIFY) begin
				if (pow2_ok) begin
					obits_q <= OBW'($countones(top_q));
				end else if (out_free) begin
					obits_q       <= '0;
					table_valid_q <= 1'b0;
				end
			end
			if (state_q == sddu_pkg::ST_DONE && out_free) table_valid_q <= 1'b1;
			mv_s1_q <= (state_q == sddu_pkg::ST_CLEAR) && ((NW + CTW)'(c_q) < (NW + CTW)'(n_w));
			pv_s1_q <= (state_q == sddu_pkg::ST_PAIR_J);
			pv_s2_q <= pv_s1_q;
			qv_s1_q <= (state_q == sddu_pkg::ST_Q_SCAN);
			// keep the best match while the held word waits for the sink
			if (state_q == sddu_pkg::ST_IDLE ||
					(state_q == sddu_pkg::ST_Q_EMIT && state_d == sddu_pkg::ST_Q_SCAN)) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
			if (state_q == sddu_pkg::ST_IDLE) begin
				pend_v_q <= 1'b0;
			end else if (state_q == sddu_pkg::ST_Q_EMIT && found_q && (!pend_v_q || out_free)) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= push_status;
			out_od_q     <= push_od;
			out_cnt_q    <= push_cnt;
			out_last_q   <= push_last;
		end
		if (req_acc) begin
			c_q   <= '0;
			i_q   <= '0;
			top_q <= '0;
			r_q   <= IB'(req_ch.index);
			od_q  <= '0;
		end else begin
			if (state_q == sddu_pkg::ST_CLEAR) c_q <= c_q + CTW'(1);
			if (mv_s1_q && (sb_rdata > top_q)) top_q <= sb_rdata;
			if (state_q == sddu_pkg::ST_PAIR_S) begin
				si_q <= sb_rdata;
				j_q  <= '0;
			end
			if (state_q == sddu_pkg::ST_PAIR_J) j_q <= j_q + IB'(1);
			if (state_q == sddu_pkg::ST_PAIR_D && !pv_s1_q && !pv_s2_q) i_q <= i_q + IB'(1);
			if (state_q == sddu_pkg::ST_Q_SCAN) od_q <= od_q + OB'(1);
			if (state_q == sddu_pkg::ST_Q_EMIT) od_q <= '0;
		end
		pj_s1_q  <= j_q;
		pa_s2_q  <= ct_raddr;
		qod_s1_q <= od_q;
		if (better) begin
			best_cnt_q <= ct_rdata;
			best_od_q  <= qod_s1_q;
		end
		if (state_q == sddu_pkg::ST_Q_EMIT && found_q && (!pend_v_q || out_free)) begin
			pend_cnt_q <= best_cnt_q;
			pend_od_q  <= best_od_q;
		end
	end

	// pair pipeline must be drained before a new row index or the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sddu_pkg::ST_IDLE || state_q == sddu_pkg::ST_PAIR_I) |-> !pv_s1_q && !pv_s2_q)
		else $error("pair pipeline busy outside the pair walk");

	// error words always close their item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != sddu_pkg::STAT_OK) |-> out_last_q)
		else $error("error word without last");

	// count RAM is written only while building
	assert property (@(posedge clk) disable iff (!arst_n)
		ct_we |-> (state_q == sddu_pkg::ST_CLEAR || state_q == sddu_pkg::ST_PAIR_J ||
			state_q == sddu_pkg::ST_PAIR_D || state_q == sddu_pkg::ST_PAIR_I))
		else $error("count RAM write outside construction");

	// a word never gets pushed over one that is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output register overrun");
endmodule
`default_nettype wire

// File: rtl/core/sddu_ram.sv
`default_nettype none
module sddu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;

	localparam int WDOG_LIMIT = 60000;
	localparam int N_DIR      = 21;

	typedef struct {
		logic                  req;
		logic [5:0]            idx;
		logic [5:0]            val;
		logic                  lst;
		bit                    typed;
		sddu_pkg::status_t     st;
	} stim_row_t;

	typedef struct {
		sddu_pkg::status_t     st;
		logic [5:0]            od;
		logic [6:0]            cnt;
		logic                  lst;
	} ddt_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [sddu_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [sddu_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [sddu_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	sddu_req_if req_ch();
	sddu_rsp_if rsp_ch();

	sbox_difference_distribution_unit u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_ch(req_ch), .rsp_ch(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block state
	logic [2:0]  width_reg = 3'd4;
	logic [5:0]  sbox_sh [64];
	int          ddt_cnt [64][64];
	int          out_bits = 0;
	bit          ddt_valid = 0;

	ddt_word_t   words_due[$];
	stim_row_t   dir_rows[N_DIR];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          quiet = 0;
	int          rsp_stall = 0;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic int sbox_size();
		int b;
		b = width_reg;
		if (b < 1) b = 1;
		if (b > sddu_pkg::MAX_IN_BITS) b = sddu_pkg::MAX_IN_BITS;
		return 1 << b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic push_word(input sddu_pkg::status_t st, input int od, input int cnt,
			input logic lst);
		ddt_word_t w;
		w.st = st; w.od = od[5:0]; w.cnt = cnt[6:0]; w.lst = lst;
		words_due = {words_due, w};
	endtask

	// builds the difference table from the shadow S-box; returns the load status
	function automatic sddu_pkg::status_t build_ddt(input int n);
		int top;
		top = 0;
		for (int a = 0; a < 64; a++)
			for (int d = 0; d < 64; d++) ddt_cnt[a][d] = 0;
		for (int i = 0; i < n; i++)
			if (sbox_sh[i] > top) top = sbox_sh[i];
		if ($countones(top + 1) != 1) begin
			ddt_valid = 0;
			out_bits = 0;
			return sddu_pkg::STAT_NOT_POW2;
		end
		out_bits = $countones(top);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				ddt_cnt[i ^ j][sbox_sh[i] ^ sbox_sh[j]]++;
		ddt_valid = 1;
		return sddu_pkg::STAT_OK;
	endfunction

	task automatic predict_ddt(input logic req, input logic [5:0] idx, input logic [5:0] val,
			input logic lst);
		int n, osz, k;
		sddu_pkg::status_t st;
		n = sbox_size();
		if (req == sddu_pkg::REQ_LOAD) begin
			st = sddu_pkg::STAT_OK;
			if (idx >= n) st = sddu_pkg::STAT_RANGE;
			else begin
				sbox_sh[idx] = val;
				if (lst) st = build_ddt(n);
			end
			push_word(st, 0, 0, 1'b1);
		end else if (!ddt_valid) push_word(sddu_pkg::STAT_NOT_BUILT, 0, 0, 1'b1);
		else if (idx >= n) push_word(sddu_pkg::STAT_RANGE, 0, 0, 1'b1);
		else begin
			osz = 1 << out_bits;
			k = 0;
			for (int c = n; c >= 1; c--)
				for (int od = 0; od < osz; od++)
					if (ddt_cnt[idx][od] == c) begin
						push_word(sddu_pkg::STAT_OK, od, c, 1'b0);
						k++;
					end
			if (k == 0) push_word(sddu_pkg::STAT_OK, 0, 0, 1'b1);
			else words_due[$].lst = 1'b1;
		end
	endtask

	task automatic send_item(input stim_row_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req;
		req_ch.index <= r.idx;
		req_ch.entry_value <= r.val;
		req_ch.last_entry <= r.lst;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (r.typed) push_word(r.st, 0, 0, 1'b1);
		else predict_ddt(r.req, r.idx, r.val, r.lst);
	endtask

	task automatic send(input logic req, input int idx, input int val, input logic lst);
		stim_row_t r;
		r.req = req; r.idx = idx[5:0]; r.val = val[5:0]; r.lst = lst;
		r.typed = 0; r.st = sddu_pkg::STAT_OK;
		send_item(r);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_width(input logic [2:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= sddu_pkg::ADDR_IN_BITS;
		pwdata <= {29'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		width_reg = v;
		ddt_valid = 0;
		// read back
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[2:0] !== v) report($sformatf("in_bits read %0d, wrote %0d", prdata[2:0], v));
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_row(input int k, input logic req, input int idx, input int val,
			input logic lst, input bit typed, input sddu_pkg::status_t st);
		dir_rows[k].req = req; dir_rows[k].idx = idx[5:0]; dir_rows[k].val = val[5:0];
		dir_rows[k].lst = lst; dir_rows[k].typed = typed; dir_rows[k].st = st;
	endtask

	// response side: random back-pressure and in-order check
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (words_due.size() == 0)
				report($sformatf("unexpected word status %0d diff %0d count %0d",
					rsp_ch.status, rsp_ch.out_diff, rsp_ch.pair_count));
			else begin
				ddt_word_t w;
				w = words_due.pop_front();
				if (rsp_ch.status !== w.st)
					report($sformatf("status %0d, want %0d", rsp_ch.status, w.st));
				if (rsp_ch.out_diff !== w.od)
					report($sformatf("out_diff %0d, want %0d", rsp_ch.out_diff, w.od));
				if (rsp_ch.pair_count !== w.cnt)
					report($sformatf("pair_count %0d, want %0d", rsp_ch.pair_count, w.cnt));
				if (rsp_ch.last !== w.lst)
					report($sformatf("last %0b, want %0b", rsp_ch.last, w.lst));
			end
		end
		if (rsp_stall > 0) begin
			rsp_stall <= rsp_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_stall <= pick_gap();
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
			$display("** sbox_difference_distribution_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [2:0] widths [9] = '{3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4, 3'd3};
		int n, vmask, k;

		req_ch.valid = 1'b0; req_ch.req_type = sddu_pkg::REQ_LOAD; req_ch.index = '0;
		req_ch.entry_value = '0; req_ch.last_entry = 1'b0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < 64; i++) sbox_sh[i] = '0;

		// after reset: 16-entry S-box, one entry at 63 so the output size is 64
		set_row(0, sddu_pkg::REQ_QUERY, 0, 63, 1'b0, 1, sddu_pkg::STAT_NOT_BUILT);
		set_row(1, sddu_pkg::REQ_LOAD, 63, 63, 1'b1, 1, sddu_pkg::STAT_RANGE);
		set_row(2, sddu_pkg::REQ_LOAD, 16, 0, 1'b0, 1, sddu_pkg::STAT_RANGE);
		for (int i = 0; i < 16; i++)
			set_row(3 + i, sddu_pkg::REQ_LOAD, i, (i == 0) ? 63 : ((i * 7 + 3) & 15), i == 15, 0,
				sddu_pkg::STAT_OK);
		set_row(19, sddu_pkg::REQ_QUERY, 15, 0, 1'b1, 0, sddu_pkg::STAT_OK);
		set_row(20, sddu_pkg::REQ_QUERY, 63, 0, 1'b0, 1, sddu_pkg::STAT_RANGE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) send_item(dir_rows[i]);
		send(sddu_pkg::REQ_QUERY, 0, 0, 1'b0);
		drain();

		for (int p = 0; p < 9; p++) begin
			quiet = (p % 3 == 1);
			write_width(widths[p]);
			n = sbox_size();
			send(sddu_pkg::REQ_QUERY, $urandom_range(0, n - 1), $urandom, 1'b0);
			vmask = (1 << $urandom_range(0, 6)) - 1;
			for (int i = 0; i < n; i++) begin
				k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : ($urandom & vmask);
				if (i == n - 1 && $urandom_range(0, 1)) k = vmask;
				send(sddu_pkg::REQ_LOAD, i, k, i == n - 1);
				if (n < 64 && $urandom_range(0, 15) == 0)
					send(sddu_pkg::REQ_LOAD, $urandom_range(n, 63), $urandom, 1'($urandom));
			end
			drain();
			for (int q = 0; q < 8; q++) begin
				if (q == 4 && $urandom_range(0, 1)) begin
					// rebuild from a fresh entry, possibly breaking the power-of-two size
					send(sddu_pkg::REQ_LOAD, $urandom_range(0, n - 1), $urandom, 1'b1);
				end
				if ($urandom_range(0, 5) == 0)
					send(sddu_pkg::REQ_QUERY, $urandom_range(0, 63), $urandom, 1'($urandom));
				else
					send(sddu_pkg::REQ_QUERY, $urandom_range(0, n - 1), $urandom, 1'($urandom));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** sbox_difference_distribution_unit: PASSED **");
		else
			$display("** sbox_difference_distribution_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/sddu_pkg.sv
rtl/core/sddu_req_if.sv
rtl/core/sddu_rsp_if.sv
rtl/core/sddu_ram.sv
rtl/core/sbox_difference_distribution_unit.sv
verif/tb_top.sv
